// ----- hdl/pbsa_pkg.sv -----
// Shared types and constants for the BAR sizing and allocation block.
// No dependencies; used by pbsa_alloc and pci_bar_size_and_assign_top.
`default_nettype none

package pbsa_pkg;

    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned S_TDATA_W  = 64;
    localparam int unsigned M_TDATA_W  = 168;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd1;

    localparam logic [WORD_W-1:0] WORD_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] SIZE_MASK     = 32'hFFFF_FFF0;
    localparam logic [3:0]        FLAGS_MASK    = 4'hF;
    localparam logic [1:0]        TYPE_64BIT    = 2'b10;

    typedef enum logic [1:0] {
        STATUS_SKIPPED  = 2'd0,
        STATUS_ASSIGNED = 2'd1,
        STATUS_NO_SPACE = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    assigned_address;
        logic [WORD_W-1:0]    region_size;
        logic [WORD_W-1:0]    low_word_out;
        logic [WORD_W-1:0]    high_word_out;
        logic                 uses_next_slot;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/pbsa_alloc.sv -----
// Combinational BAR decode, alignment and window check for one request.
// Depends on pbsa_pkg.
`default_nettype none

module pbsa_alloc (
    input  wire logic [pbsa_pkg::WORD_W-1:0] original_word,
    input  wire logic [pbsa_pkg::WORD_W-1:0] probe_readback,
    input  wire logic [pbsa_pkg::ADDR_W-1:0] free_address,
    input  wire logic [pbsa_pkg::ADDR_W:0]   window_limit,
    output pbsa_pkg::result_t                result,
    output logic [pbsa_pkg::ADDR_W-1:0]      free_address_next
);

    logic [pbsa_pkg::WORD_W-1:0] size32;
    logic [pbsa_pkg::ADDR_W-1:0] align_mask;
    logic [pbsa_pkg::ADDR_W:0]   sum;
    logic [pbsa_pkg::ADDR_W-1:0] addr;
    logic [pbsa_pkg::ADDR_W:0]   region_end;
    logic                        skip;
    logic                        no_space;
    logic                        wide;

    always_comb begin
        size32     = (~(probe_readback & pbsa_pkg::SIZE_MASK)) + 32'd1;
        align_mask = {32'd0, size32 - 32'd1};
        sum        = {1'b0, free_address} + {1'b0, align_mask};
        addr       = sum[pbsa_pkg::ADDR_W-1:0] & ~align_mask;
        region_end = {1'b0, addr} + {33'd0, size32};
        wide       = (original_word[2:1] == pbsa_pkg::TYPE_64BIT);
        skip       = (original_word == '0) || (original_word == pbsa_pkg::WORD_ALL_ONES)
                     || original_word[0] || (size32 == '0);
        no_space   = sum[pbsa_pkg::ADDR_W] || (region_end > window_limit);

        result            = '0;
        result.status     = pbsa_pkg::STATUS_SKIPPED;
        free_address_next = free_address;
        if (!skip) begin
            if (no_space) begin
                result.status = pbsa_pkg::STATUS_NO_SPACE;
            end else begin
                result.status           = pbsa_pkg::STATUS_ASSIGNED;
                result.assigned_address = addr;
                result.region_size      = size32;
                free_address_next       = region_end[pbsa_pkg::ADDR_W-1:0];
                if (wide) begin
                    result.low_word_out   = addr[31:0];
                    result.high_word_out  = addr[63:32];
                    result.uses_next_slot = 1'b1;
                end else begin
                    result.low_word_out = addr[31:0]
                                          | {28'd0, original_word[3:0] & pbsa_pkg::FLAGS_MASK};
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pci_bar_size_and_assign_top.sv -----
// Top level of the BAR sizing and aligned allocation block.
// Depends on pbsa_pkg and pbsa_alloc.
//
// Usage:
//   s_ channel carries one BAR probe per request: the original BAR word and
//   the word read back after writing all ones. m_ channel returns one result
//   per request: status, aligned address, size, words to write back and the
//   64-bit flag. Requests and results move on tvalid && tready.
//   Configuration: cfg_we with cfg_index 0 writes window_base (and reloads
//   the allocation pointer), index 1 writes window_length; other indexes are
//   ignored. Write only while no request is in flight.
//   Path: an accepted request is held in the input register; its result is
//   registered when the result register is empty or m_tready is high.
//   Throughput: one request per cycle while m_tready stays high; the pointer
//   update of one request is visible to the next one in the following cycle
//   through a single align/add/compare path.
//   Reset (aresetn low, synchronous): both stages empty, window base, length
//   and pointer cleared to zero.
//   Stall: while m_tready is low the result holds; one more request can
//   still enter the input register, after which s_tready drops.
`default_nettype none

module pci_bar_size_and_assign_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [pbsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pbsa_pkg::ADDR_W-1:0]       cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] original_word, [63:32] probe_readback
    input  wire logic [pbsa_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] status, [65:2] assigned_address, [97:66] region_size,
    // [129:98] low_word_out, [161:130] high_word_out, [162] uses_next_slot,
    // [167:163] zero
    output logic [pbsa_pkg::M_TDATA_W-1:0]         m_tdata
);

    logic                             in_valid_reg;
    logic [pbsa_pkg::S_TDATA_W-1:0]   in_data_reg;
    logic                             out_valid_reg;
    pbsa_pkg::result_t                out_result_reg;
    logic [pbsa_pkg::ADDR_W-1:0]      base_reg;
    logic [pbsa_pkg::ADDR_W-1:0]      length_reg;
    logic [pbsa_pkg::ADDR_W:0]        limit_reg;
    logic [pbsa_pkg::ADDR_W-1:0]      free_reg;
    logic [pbsa_pkg::ADDR_W-1:0]      free_next;
    pbsa_pkg::result_t                result;
    logic                             out_ready;
    logic                             advance;
    logic                             s_accept;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    pbsa_alloc u_alloc (
        .original_word     (in_data_reg[31:0]),
        .probe_readback    (in_data_reg[63:32]),
        .free_address      (free_reg),
        .window_limit      (limit_reg),
        .result            (result),
        .free_address_next (free_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            length_reg    <= '0;
            limit_reg     <= '0;
            free_reg      <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we && (cfg_index == pbsa_pkg::REG_WINDOW_BASE)) begin
                base_reg  <= cfg_wdata;
                free_reg  <= cfg_wdata;
                limit_reg <= {1'b0, cfg_wdata} + {1'b0, length_reg};
            end else if (cfg_we && (cfg_index == pbsa_pkg::REG_WINDOW_LENGTH)) begin
                length_reg <= cfg_wdata;
                limit_reg  <= {1'b0, base_reg} + {1'b0, cfg_wdata};
            end else if (advance) begin
                free_reg <= free_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_result_reg.uses_next_slot,
                       out_result_reg.high_word_out,
                       out_result_reg.low_word_out,
                       out_result_reg.region_size,
                       out_result_reg.assigned_address,
                       out_result_reg.status};

    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cfg_we && !(advance && result.status == pbsa_pkg::STATUS_ASSIGNED))
        |=> $stable(free_reg))
        else $error("allocation pointer moved without an assignment");

    a_ptr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cfg_we && advance && result.status == pbsa_pkg::STATUS_ASSIGNED)
        |=> free_reg == $past(result.assigned_address) + {32'd0, $past(result.region_size)})
        else $error("allocation pointer not advanced past the region");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.status != pbsa_pkg::STATUS_ASSIGNED)
        |-> (out_result_reg.assigned_address == '0 && out_result_reg.region_size == '0
             && out_result_reg.low_word_out == '0 && !out_result_reg.uses_next_slot))
        else $error("unassigned result carries nonzero fields");

    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> limit_reg == {1'b0, base_reg} + {1'b0, length_reg})
        else $error("window limit out of step with base and length");

endmodule

`default_nettype wire

// ----- tb/pci_bar_size_and_assign_top_tb.sv -----
// Self-checking testbench for pci_bar_size_and_assign_top: BAR probes in, allocation results out.
// Predicts each result from its own copy of the window and allocation pointer.
// Depends on pbsa_pkg and the RTL under hdl/.
`default_nettype none

module pci_bar_size_and_assign_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 cfg_we;
    logic [pbsa_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [pbsa_pkg::ADDR_W-1:0]          cfg_wdata;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [pbsa_pkg::S_TDATA_W-1:0]       s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [pbsa_pkg::M_TDATA_W-1:0]       m_tdata;

    logic [pbsa_pkg::ADDR_W-1:0]          win_base;
    logic [pbsa_pkg::ADDR_W-1:0]          win_len;
    logic [pbsa_pkg::ADDR_W-1:0]          alloc_ptr;

    pbsa_pkg::result_t      predicted_bar_results[$];
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    int                     hold_requests = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;

    pci_bar_size_and_assign_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic pbsa_pkg::result_t assign_bar(
            input logic [pbsa_pkg::WORD_W-1:0] orig,
            input logic [pbsa_pkg::WORD_W-1:0] rb);
        pbsa_pkg::result_t              r;
        logic [pbsa_pkg::WORD_W-1:0]    sz32;
        logic [pbsa_pkg::ADDR_W-1:0]    mask;
        logic [pbsa_pkg::ADDR_W:0]      sum;
        logic [pbsa_pkg::ADDR_W:0]      addr;
        logic [pbsa_pkg::ADDR_W:0]      fin;
        logic [pbsa_pkg::ADDR_W:0]      lim;
        r = '0;
        r.status = pbsa_pkg::STATUS_SKIPPED;
        if (orig == '0 || orig == pbsa_pkg::WORD_ALL_ONES || orig[0])
            return r;
        sz32 = ~(rb & pbsa_pkg::SIZE_MASK) + 32'd1;
        if (sz32 == '0)
            return r;
        mask = {32'd0, sz32} - 64'd1;
        sum  = {1'b0, alloc_ptr} + {1'b0, mask};
        addr = {1'b0, sum[pbsa_pkg::ADDR_W-1:0] & ~mask};
        fin  = addr + {33'd0, sz32};
        lim  = {1'b0, win_base} + {1'b0, win_len};
        if (sum[pbsa_pkg::ADDR_W] || fin > lim) begin
            r.status = pbsa_pkg::STATUS_NO_SPACE;
            return r;
        end
        alloc_ptr = fin[pbsa_pkg::ADDR_W-1:0];
        r.status = pbsa_pkg::STATUS_ASSIGNED;
        r.assigned_address = addr[pbsa_pkg::ADDR_W-1:0];
        r.region_size = sz32;
        if (orig[2:1] == pbsa_pkg::TYPE_64BIT) begin
            r.low_word_out = addr[31:0];
            r.high_word_out = addr[63:32];
            r.uses_next_slot = 1'b1;
        end else begin
            r.low_word_out = addr[31:0] | {28'd0, orig[3:0] & pbsa_pkg::FLAGS_MASK};
        end
        return r;
    endfunction

    function automatic logic [63:0] random_probe();
        logic [pbsa_pkg::WORD_W-1:0] orig;
        logic [pbsa_pkg::WORD_W-1:0] rb;
        int                k;
        int                sel;
        sel = $urandom_range(99);
        orig = $urandom;
        orig[0] = 1'b0;
        k = ($urandom_range(9) == 0) ? $urandom_range(31, 20) : $urandom_range(19, 4);
        rb = ~((32'd1 << k) - 32'd1) | {28'd0, orig[3:0]};
        if (sel < 2)
            orig = '0;
        else if (sel < 4)
            orig = pbsa_pkg::WORD_ALL_ONES;
        else if (sel < 7)
            orig[0] = 1'b1;
        else if (sel < 13)
            rb = $urandom;
        else if (sel < 15)
            rb = {28'd0, 4'($urandom)};
        if (orig == '0 && sel >= 2)
            orig = 32'h0000_0008;
        return {rb, orig};
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: expected %h, got %h", $realtime, field, exp_v, act_v);
    endtask

    task automatic check_result(input logic [pbsa_pkg::M_TDATA_W-1:0] data);
        pbsa_pkg::result_t exp_r;
        if (predicted_bar_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t result with no request pending: %h", $realtime, data);
            return;
        end
        exp_r = predicted_bar_results.pop_front();
        if (data[1:0] !== exp_r.status)
            report_mismatch("status", 64'(exp_r.status), 64'(data[1:0]));
        if (data[65:2] !== exp_r.assigned_address)
            report_mismatch("assigned_address", exp_r.assigned_address, data[65:2]);
        if (data[97:66] !== exp_r.region_size)
            report_mismatch("region_size", 64'(exp_r.region_size), 64'(data[97:66]));
        if (data[129:98] !== exp_r.low_word_out)
            report_mismatch("low_word_out", 64'(exp_r.low_word_out), 64'(data[129:98]));
        if (data[161:130] !== exp_r.high_word_out)
            report_mismatch("high_word_out", 64'(exp_r.high_word_out), 64'(data[161:130]));
        if (data[162] !== exp_r.uses_next_slot)
            report_mismatch("uses_next_slot", 64'(exp_r.uses_next_slot), 64'(data[162]));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pci_bar_size_and_assign_top: mismatch");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_probe(input logic [pbsa_pkg::WORD_W-1:0] orig,
                              input logic [pbsa_pkg::WORD_W-1:0] rb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rb, orig};
        do @(posedge aclk); while (!s_tready);
        predicted_bar_results.push_back(assign_bar(orig, rb));
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (predicted_bar_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [pbsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbsa_pkg::ADDR_W-1:0] val);
        wait_drain();
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == pbsa_pkg::REG_WINDOW_BASE) begin
            win_base = val;
            alloc_ptr = val;
        end else if (idx == pbsa_pkg::REG_WINDOW_LENGTH) begin
            win_len = val;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int n);
        logic [63:0] p;
        repeat (n) begin
            p = random_probe();
            send_probe(p[31:0], p[63:32]);
        end
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_reg(pbsa_pkg::REG_WINDOW_BASE, 64'h0000_0000_F000_0000);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'h0000_0000_2000_0000);
        send_probe(32'h0000_0000, 32'hFFFF_F000);
        send_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_probe(32'h0000_0001, 32'hFFFF_FF01);
        send_probe(32'hFFFF_FFFD, 32'h0000_0000);
        send_probe(32'h0000_0008, 32'h0000_000F);
        send_probe(32'h0000_0008, 32'hFFFF_F008);
        send_probe(32'h0000_0002, 32'hFFFF_0002);
        send_probe(32'h0000_0006, 32'hFFF0_0006);
        send_probe(32'h0000_000C, 32'hFFE0_000C);
        send_probe(32'h0000_0004, 32'hFFFF_5004);
        send_probe(32'h0000_0004, 32'h8000_0004);
        send_probe(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        send_probe(32'h1234_5670, 32'hF000_0000);
        send_probe(32'h8000_0004, 32'hFFFF_FFF4);
        write_reg(pbsa_pkg::REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_0000);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_probe(32'h0000_0004, 32'hFFFF_F004);
        send_probe(32'h0000_0008, 32'hC000_0008);
        send_probe(32'h0000_0008, 32'hFFFF_FFF8);
        write_reg(pbsa_pkg::REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'h0000_0000_0000_0010);
        send_probe(32'h0000_0004, 32'hFFFF_FFF4);
        send_probe(32'h0000_0008, 32'hFFFF_FFF8);
        write_reg(8'd2, {$urandom, $urandom});
        write_reg(8'hFF, {$urandom, $urandom});
        send_probe(32'h0000_0008, 32'hFFFF_FFF8);
        write_reg(pbsa_pkg::REG_WINDOW_BASE, 64'd0);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'd0);
        send_probe(32'h0000_0008, 32'hFFFF_FFF8);
    endtask

    task automatic test_random_phase(input int src_pct, input int sink_pct,
                                     input logic [pbsa_pkg::ADDR_W-1:0] base,
                                     input logic [pbsa_pkg::ADDR_W-1:0] len, input int n);
        write_reg(pbsa_pkg::REG_WINDOW_BASE, base);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, len);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        send_random(n);
    endtask

    task automatic test_long_backpressure();
        write_reg(pbsa_pkg::REG_WINDOW_BASE, 64'h0000_1000_0000_0000);
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'h0000_0100_0000_0000);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_requests++;
        send_random(150);
    endtask

    task automatic test_drain_pause();
        write_reg(pbsa_pkg::REG_WINDOW_BASE, {$urandom, 32'd0});
        write_reg(pbsa_pkg::REG_WINDOW_LENGTH, 64'h0000_0008_0000_0000);
        src_idle_pct = 34;
        sink_stall_pct = 34;
        send_random(40);
        wait_drain();
        send_random(40);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        win_base = '0;
        win_len = '0;
        alloc_ptr = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_phase(0, 0, 64'd0, 64'h0000_0010_0000_0000, 320);
        test_random_phase(69, 0, {$urandom, $urandom}, 64'h0000_0004_0000_0000, 320);
        test_random_phase(0, 69, 64'hFFFF_FFF0_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 320);
        test_random_phase(34, 34, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 320);
        test_random_phase(34, 34, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 60);
        test_random_phase(0, 0, 64'd0, 64'd0, 60);
        test_long_backpressure();
        test_drain_pause();

        wait_drain();
        repeat (10) @(negedge aclk);
        if (error_count == 0)
            $display("pci_bar_size_and_assign_top: match");
        else
            $display("pci_bar_size_and_assign_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
